>>> rtl/qoipe_pkg.sv
package qoipe_pkg;

  localparam int INDEX_ENTRIES = 64;
  localparam int SLOT_W = $clog2(INDEX_ENTRIES);
  localparam int MAX_BYTES = 5;
  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF = 8'h40;
  localparam logic [7:0] OP_LUMA = 8'h80;
  localparam logic [7:0] OP_RUN = 8'hC0;
  localparam logic [7:0] OP_RGB = 8'hFE;

  localparam logic [5:0] RUN_LIMIT = 6'd62;
  localparam logic [SLOT_W-1:0] HASH_BIAS = SLOT_W'((255 * 11) % INDEX_ENTRIES);

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0] count;
    logic frame_end;
  } rec_t;

endpackage

>>> rtl/qoi_style_pixel_encoder_core.sv
// QOI-style RGB pixel encoder.
// The input channel takes one pixel per transaction together with the pixel at
// the same place in the previous frame and a frame_end flag. The result channel
// gives one byte of the coded stream per transaction; last_of_item marks the final
// byte that a pixel causes and frame_done the final byte of a frame. A pixel that
// only extends a run gives no bytes.
// A one-bit register selects difference mode; write it only while the block is idle.
// Pixels pass a two-stage classifier (coding and hashing, then table lookup and
// opcode choice) into a queue of byte groups, which a serializer drains.
// Pixels pass the stage-one and stage-two registers and the queue before their
// first byte enters the output register. Throughput: one pixel per cycle while
// pixels average at most one byte each; one byte leaves per cycle unless stalled.
// When the receiver stalls, the output byte holds, the queue fills and the input
// stall then rises. Synchronous reset clears the run, previous pixel, seen-color
// table and register, and all pipeline and queue state; no item is lost after it.
module qoi_style_pixel_encoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_pixel_red,
  input  logic [7:0] in_pixel_green,
  input  logic [7:0] in_pixel_blue,
  input  logic [7:0] in_ref_red,
  input  logic [7:0] in_ref_green,
  input  logic [7:0] in_ref_blue,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_code_byte,
  output logic       out_last_of_item,
  output logic       out_frame_done
);
  import qoipe_pkg::*;

  logic diff_mode_r;
  logic q_push, q_full, q_pop, q_empty;
  rec_t q_rec, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_mode_r <= 1'b0;
    end else if (cfg_write_en) begin
      diff_mode_r <= cfg_write_data;
    end
  end

  qoipe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .diff_mode      (diff_mode_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_red   (in_pixel_red),
    .in_pixel_green (in_pixel_green),
    .in_pixel_blue  (in_pixel_blue),
    .in_ref_red     (in_ref_red),
    .in_ref_green   (in_ref_green),
    .in_ref_blue    (in_ref_blue),
    .in_frame_end   (in_frame_end),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (q_rec)
  );

  qoipe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_rec),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  qoipe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_byte    (out_code_byte),
    .out_last_of_item (out_last_of_item),
    .out_frame_done   (out_frame_done)
  );

endmodule

>>> rtl/qoipe_front.sv
module qoipe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 diff_mode,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_pixel_red,
  input  logic [7:0]           in_pixel_green,
  input  logic [7:0]           in_pixel_blue,
  input  logic [7:0]           in_ref_red,
  input  logic [7:0]           in_ref_green,
  input  logic [7:0]           in_ref_blue,
  input  logic                 in_frame_end,
  input  logic                 q_full,
  output logic                 q_push,
  output qoipe_pkg::rec_t      q_rec
);
  import qoipe_pkg::*;

  // Stage one: coded pixel and seen-color slot.
  logic [7:0] cr_in, cg_in, cb_in;
  logic [5:0] r6, g6, b6;
  logic [SLOT_W-1:0] slot_in;

  logic              s1_valid_r;
  logic [23:0]       s1_px_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_end_r;

  logic              s2_valid_r;
  logic [23:0]       s2_px_r;
  logic [SLOT_W-1:0] s2_slot_r;
  logic              s2_end_r;
  logic [23:0]       rd_data_r;

  logic [23:0]              seen_mem [INDEX_ENTRIES];
  logic [INDEX_ENTRIES-1:0] seen_valid_r;
  logic                     wr_valid_r;
  logic [SLOT_W-1:0]        wr_slot_r;
  logic [23:0]              wr_data_r;

  logic [23:0] last_r;
  logic [5:0]  run_r;
  logic [5:0]  run_nxt;

  logic accept, adv1, fire2, wr_en;

  assign cr_in = diff_mode ? (in_ref_red - in_pixel_red) : in_pixel_red;
  assign cg_in = diff_mode ? (in_ref_green - in_pixel_green) : in_pixel_green;
  assign cb_in = diff_mode ? (in_ref_blue - in_pixel_blue) : in_pixel_blue;
  assign r6 = cr_in[5:0];
  assign g6 = cg_in[5:0];
  assign b6 = cb_in[5:0];
  assign slot_in = r6 + (r6 << 1) + g6 + (g6 << 2) + (b6 << 3) - b6 + HASH_BIAS;

  assign fire2 = s2_valid_r && !q_full;
  assign adv1 = s1_valid_r && (!s2_valid_r || fire2);
  assign in_stall = s1_valid_r && !adv1;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept || (s1_valid_r && !adv1);
      s2_valid_r <= adv1 || (s2_valid_r && !fire2);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r <= {cr_in, cg_in, cb_in};
      s1_slot_r <= slot_in;
      s1_end_r <= in_frame_end;
    end
    if (adv1) begin
      s2_px_r <= s1_px_r;
      s2_slot_r <= s1_slot_r;
      s2_end_r <= s1_end_r;
      rd_data_r <= seen_mem[s1_slot_r];
    end
    if (wr_en && fire2) begin
      seen_mem[s2_slot_r] <= s2_px_r;
    end
  end

  // Stage two: classify against the previous coded pixel and the table.
  logic [7:0] cr, cg, cb, lr, lg, lb;
  logic signed [7:0] dr, dg, db;
  logic signed [9:0] rr, rb;
  logic eq, fwd, hit, diff_ok, luma_ok;
  logic [23:0] seen_raw, seen;
  logic [MAX_BYTES-1:0][7:0] bytes_v;
  logic [CNT_W-1:0] n;

  assign {cr, cg, cb} = s2_px_r;
  assign {lr, lg, lb} = last_r;
  assign dr = cr - lr;
  assign dg = cg - lg;
  assign db = cb - lb;
  assign rr = 10'(dr) - 10'(dg);
  assign rb = 10'(db) - 10'(dg);
  assign eq = (s2_px_r == last_r);
  assign fwd = wr_valid_r && (wr_slot_r == s2_slot_r);
  assign seen_raw = fwd ? wr_data_r : rd_data_r;
  assign seen = seen_valid_r[s2_slot_r] ? seen_raw : 24'd0;
  assign hit = (seen == s2_px_r);
  assign diff_ok = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1) &&
                   (db >= -8'sd2) && (db <= 8'sd1);
  assign luma_ok = (dg >= -8'sd32) && (dg <= 8'sd31) && (rr >= -10'sd8) && (rr <= 10'sd7) &&
                   (rb >= -10'sd8) && (rb <= 10'sd7);

  always_comb begin
    bytes_v = '0;
    n = '0;
    run_nxt = run_r;
    wr_en = 1'b0;
    if (eq) begin
      if (run_r == RUN_LIMIT - 6'd1) begin
        bytes_v[n] = OP_RUN | {2'b00, RUN_LIMIT - 6'd1};
        n = n + 1'b1;
        run_nxt = '0;
      end else begin
        run_nxt = run_r + 6'd1;
      end
    end else begin
      if (run_r != 6'd0) begin
        bytes_v[n] = OP_RUN | {2'b00, run_r - 6'd1};
        n = n + 1'b1;
      end
      run_nxt = '0;
      if (hit) begin
        bytes_v[n] = OP_INDEX | {{(8 - SLOT_W){1'b0}}, s2_slot_r};
        n = n + 1'b1;
      end else begin
        wr_en = 1'b1;
        if (diff_ok) begin
          bytes_v[n] = OP_DIFF | {2'b00, 2'(dr + 8'sd2), 2'(dg + 8'sd2), 2'(db + 8'sd2)};
          n = n + 1'b1;
        end else if (luma_ok) begin
          bytes_v[n] = OP_LUMA | {2'b00, 6'(dg + 8'sd32)};
          n = n + 1'b1;
          bytes_v[n] = {4'(rr + 10'sd8), 4'(rb + 10'sd8)};
          n = n + 1'b1;
        end else begin
          bytes_v[n] = OP_RGB;
          n = n + 1'b1;
          bytes_v[n] = cr;
          n = n + 1'b1;
          bytes_v[n] = cg;
          n = n + 1'b1;
          bytes_v[n] = cb;
          n = n + 1'b1;
        end
      end
    end
    if (s2_end_r && (run_nxt != 6'd0)) begin
      bytes_v[n] = OP_RUN | {2'b00, run_nxt - 6'd1};
      n = n + 1'b1;
    end
  end

  assign q_push = fire2 && (n != '0);
  assign q_rec = '{bytes: bytes_v, count: n, frame_end: s2_end_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      run_r <= '0;
      seen_valid_r <= '0;
      wr_valid_r <= 1'b0;
    end else if (fire2) begin
      if (s2_end_r) begin
        last_r <= '0;
        run_r <= '0;
        seen_valid_r <= '0;
      end else begin
        last_r <= s2_px_r;
        run_r <= run_nxt;
        if (wr_en) begin
          seen_valid_r[s2_slot_r] <= 1'b1;
        end
      end
      if (wr_en) begin
        wr_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire2 && wr_en) begin
      wr_slot_r <= s2_slot_r;
      wr_data_r <= s2_px_r;
    end
  end

endmodule

>>> rtl/qoipe_fifo.sv
module qoipe_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  qoipe_pkg::rec_t push_data,
  output logic            full,
  input  logic            pop,
  output qoipe_pkg::rec_t head,
  output logic            empty
);
  import qoipe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  rec_t              store_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;
  logic              do_push, do_pop;

  assign full = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/qoipe_back.sv
module qoipe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  qoipe_pkg::rec_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_code_byte,
  output logic            out_last_of_item,
  output logic            out_frame_done
);
  import qoipe_pkg::*;

  logic [CNT_W-1:0] idx_r;
  logic             out_valid_r;
  logic [7:0]       code_r;
  logic             last_r;
  logic             done_r;
  logic             load, is_last;

  assign load = !q_empty && (!out_valid_r || !out_stall);
  assign is_last = (idx_r == q_head.count - 1'b1);
  assign q_pop = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r <= is_last ? '0 : idx_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= q_head.bytes[idx_r];
      last_r <= is_last;
      done_r <= is_last && q_head.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_code_byte = code_r;
  assign out_last_of_item = last_r;
  assign out_frame_done = done_r;

endmodule

>>> rtl/qoipe_checker.sv
module qoipe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_code_byte,
  input logic       out_last_of_item,
  input logic       out_frame_done
);

  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_reset_in_open: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("Input stalled right after reset.");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_item)
    else $error("Frame end byte is not the last byte of its pixel.");

  a_bytes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_item |=> out_valid)
    else $error("Gap inside the bytes of one pixel.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_byte) &&
      $stable(out_last_of_item) && $stable(out_frame_done))
    else $error("Stalled output transaction changed.");

endmodule

bind qoi_style_pixel_encoder_core qoipe_checker u_checker (.*);

>>> sim/testbench.sv
module testbench;
  import qoipe_pkg::*;

  localparam int LONG_HOLD = 200;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct {
    logic [7:0] code;
    bit         last;
    bit         done;
  } stream_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_write_en = 1'b0;
  logic       cfg_write_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_pixel_red = '0;
  logic [7:0] in_pixel_green = '0;
  logic [7:0] in_pixel_blue = '0;
  logic [7:0] in_ref_red = '0;
  logic [7:0] in_ref_green = '0;
  logic [7:0] in_ref_blue = '0;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_code_byte;
  logic       out_last_of_item;
  logic       out_frame_done;

  stream_byte_t expected_stream[$];
  logic [23:0]  seen_color_tbl[INDEX_ENTRIES];
  logic [23:0]  prev_coded = '0;
  logic [5:0]   run_count = '0;
  bit           diff_mode = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int err_count = 0;

  qoi_style_pixel_encoder_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_red     (in_pixel_red),
    .in_pixel_green   (in_pixel_green),
    .in_pixel_blue    (in_pixel_blue),
    .in_ref_red       (in_ref_red),
    .in_ref_green     (in_ref_green),
    .in_ref_blue      (in_ref_blue),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_byte    (out_code_byte),
    .out_last_of_item (out_last_of_item),
    .out_frame_done   (out_frame_done)
  );

  always #2 clk = ~clk;

  initial begin
    #1_600_000;
    $display("[qoi_style_pixel_encoder_core] ERROR");
    $finish;
  end

  function automatic int signed_delta(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = a - b;
    return (d >= 8'd128) ? int'(d) - 256 : int'(d);
  endfunction

  function automatic void clear_frame_state();
    foreach (seen_color_tbl[i]) seen_color_tbl[i] = '0;
    prev_coded = '0;
    run_count = '0;
  endfunction

  function automatic void encode_pixel(rgb_t pix, rgb_t refp, bit fe);
    rgb_t         c;
    logic [23:0]  px;
    logic [7:0]   codes[$];
    int           slot;
    int           dr;
    int           dg;
    int           db;
    int           rr;
    int           rb;
    stream_byte_t sb;
    c = pix;
    if (diff_mode) begin
      c.r = refp.r - pix.r;
      c.g = refp.g - pix.g;
      c.b = refp.b - pix.b;
    end
    px = c;
    if (px == prev_coded) begin
      run_count++;
      if (run_count >= RUN_LIMIT) begin
        codes.push_back(OP_RUN | 8'(RUN_LIMIT - 6'd1));
        run_count = '0;
      end
    end else begin
      if (run_count != 0) begin
        codes.push_back(OP_RUN | 8'(run_count - 6'd1));
        run_count = '0;
      end
      slot = (3 * c.r + 5 * c.g + 7 * c.b + 255 * 11) % INDEX_ENTRIES;
      if (seen_color_tbl[slot] == px) begin
        codes.push_back(OP_INDEX | 8'(slot));
      end else begin
        seen_color_tbl[slot] = px;
        dr = signed_delta(c.r, prev_coded[23:16]);
        dg = signed_delta(c.g, prev_coded[15:8]);
        db = signed_delta(c.b, prev_coded[7:0]);
        rr = dr - dg;
        rb = db - dg;
        if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
          codes.push_back(OP_DIFF | 8'(((dr + 2) << 4) | ((dg + 2) << 2) | (db + 2)));
        end else if (dg >= -32 && dg <= 31 && rr >= -8 && rr <= 7 && rb >= -8 && rb <= 7) begin
          codes.push_back(OP_LUMA | 8'(dg + 32));
          codes.push_back(8'(((rr + 8) << 4) | (rb + 8)));
        end else begin
          codes.push_back(OP_RGB);
          codes.push_back(c.r);
          codes.push_back(c.g);
          codes.push_back(c.b);
        end
      end
      prev_coded = px;
    end
    if (fe) begin
      if (run_count != 0) codes.push_back(OP_RUN | 8'(run_count - 6'd1));
      clear_frame_state();
    end
    foreach (codes[i]) begin
      sb.code = codes[i];
      sb.last = (i == codes.size() - 1);
      sb.done = sb.last && fe;
      expected_stream.push_back(sb);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  always @(posedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    stream_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stream.size() == 0) begin
        report_mismatch("unexpected output byte", out_code_byte, 0);
      end else begin
        want = expected_stream.pop_front();
        if (out_code_byte !== want.code) begin
          report_mismatch("code_byte", out_code_byte, want.code);
        end
        if (out_last_of_item !== want.last) begin
          report_mismatch("last_of_item", out_last_of_item, want.last);
        end
        if (out_frame_done !== want.done) begin
          report_mismatch("frame_done", out_frame_done, want.done);
        end
      end
    end
  end

  task automatic send_pixel(input rgb_t pix, input rgb_t refp, input bit fe);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_red <= pix.r;
    in_pixel_green <= pix.g;
    in_pixel_blue <= pix.b;
    in_ref_red <= refp.r;
    in_ref_green <= refp.g;
    in_ref_blue <= refp.b;
    in_frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_pixel(pix, refp, fe);
  endtask

  task automatic send_coded(input rgb_t coded, input bit fe);
    rgb_t refp;
    rgb_t pix;
    refp = 24'($urandom);
    pix = coded;
    if (diff_mode) begin
      pix.r = refp.r - coded.r;
      pix.g = refp.g - coded.g;
      pix.b = refp.b - coded.b;
    end
    send_pixel(pix, refp, fe);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_stream.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_diff_mode(input bit mode);
    wait_for_idle();
    cfg_write_en <= 1'b1;
    cfg_write_data <= mode;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    diff_mode = mode;
  endtask

  task automatic gen_stream(input int n_items);
    rgb_t coded;
    rgb_t last_sent;
    rgb_t palette[8];
    int   kind;
    int   reps;
    int   dg;
    int   sent;
    bit   fe;
    last_sent = '0;
    sent = 0;
    foreach (palette[i]) palette[i] = 24'($urandom);
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      reps = 1;
      coded = last_sent;
      if (kind < 20) begin
        reps = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 5);
      end else if (kind < 35) begin
        coded = palette[$urandom_range(0, 7)];
      end else if (kind < 65) begin
        coded.r = last_sent.r + 8'($urandom_range(0, 3)) - 8'd2;
        coded.g = last_sent.g + 8'($urandom_range(0, 3)) - 8'd2;
        coded.b = last_sent.b + 8'($urandom_range(0, 3)) - 8'd2;
      end else if (kind < 80) begin
        dg = $urandom_range(0, 63) - 32;
        coded.g = last_sent.g + 8'(dg);
        coded.r = last_sent.r + 8'(dg + $urandom_range(0, 15) - 8);
        coded.b = last_sent.b + 8'(dg + $urandom_range(0, 15) - 8);
      end else begin
        coded = 24'($urandom);
      end
      if (reps > n_items - sent) reps = n_items - sent;
      repeat (reps) begin
        fe = ($urandom_range(0, 39) == 0);
        send_coded(coded, fe);
        last_sent = fe ? '0 : coded;
        palette[$urandom_range(0, 7)] = coded;
        sent++;
      end
    end
  endtask

  task automatic test_raw_opcodes();
    set_diff_mode(1'b0);
    send_coded(24'h000000, 1'b0);
    send_coded(24'h000000, 1'b0);
    send_coded(24'h0100FF, 1'b0);
    send_coded(24'hFFFFFF, 1'b0);
    send_coded(24'h000000, 1'b0);
    send_coded(24'h141E19, 1'b0);
    send_coded(24'h303C37, 1'b0);
    send_coded(24'h081C1E, 1'b0);
    send_coded(24'h141E19, 1'b0);
    send_coded(24'hFF00FF, 1'b0);
    send_coded(24'h00FF00, 1'b1);
    send_coded(24'h00FF00, 1'b0);
    send_coded(24'h00FF00, 1'b0);
    send_coded(24'h00FF00, 1'b1);
    send_coded(24'h000000, 1'b0);
    send_coded(24'h000000, 1'b1);
  endtask

  task automatic test_difference_mode();
    set_diff_mode(1'b1);
    send_pixel(24'h123456, 24'h123456, 1'b0);
    send_pixel(24'h000000, 24'hFFFFFF, 1'b0);
    send_pixel(24'hFFFFFF, 24'h000000, 1'b0);
    send_pixel(24'h80FF01, 24'h7F00FE, 1'b0);
    send_pixel(24'hAA55AA, 24'h55AA55, 1'b0);
    send_pixel(24'hAA55AA, 24'h55AA55, 1'b1);
    send_pixel(24'h000000, 24'h000000, 1'b1);
  endtask

  task automatic test_run_limit();
    set_diff_mode(1'b0);
    send_coded(24'h0A141E, 1'b0);
    repeat (130) send_coded(24'h0A141E, 1'b0);
    send_coded(24'h0B141E, 1'b0);
    repeat (61) send_coded(24'h0B141E, 1'b0);
    send_coded(24'h0B141E, 1'b1);
  endtask

  task automatic test_random_phase(input int s_pct, input int r_pct, input bit mode);
    set_diff_mode(mode);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    gen_stream(55);
  endtask

  task automatic test_backpressure();
    set_diff_mode(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs <= hold_reqs + 1;
    gen_stream(40);
    wait_for_idle();
  endtask

  initial begin
    clear_frame_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 77;
    test_raw_opcodes();
    test_difference_mode();
    test_run_limit();
    test_random_phase(28, 77, 1'b1);
    test_random_phase(77, 28, 1'b0);
    test_random_phase(0, 0, 1'b1);
    test_backpressure();
    wait_for_idle();
    if (err_count == 0) begin
      $display("[qoi_style_pixel_encoder_core] OK");
    end else begin
      $display("[qoi_style_pixel_encoder_core] ERROR");
    end
    $finish;
  end

endmodule
